[rtl/generational_once_cell_table_assert.svh]
// assertion macros for the generational once-cell table
`ifndef GENERATIONAL_ONCE_CELL_TABLE_ASSERT_SVH
`define GENERATIONAL_ONCE_CELL_TABLE_ASSERT_SVH

// condition that holds at every clock edge out of reset
`define GCT_ASSERT_ALWAYS(label, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond)) \
      else $error(msg);

// same-cycle implication
`define GCT_ASSERT_IMPLIES(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define GCT_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

[rtl/gct_pkg.sv]
// types, codes and helpers shared by the once-cell table modules
package gct_pkg;

   localparam int SLOT_W      = 8;
   localparam int GEN_W       = 16;
   localparam int VAL_W       = 64;
   localparam int MODE_W      = 3;
   localparam int STATUS_W    = 3;
   localparam int GROUP_W     = 16;
   localparam int GROUP_IDX_W = 4;

   localparam logic [MODE_W-1:0] MODE_CREATE    = 3'd0;
   localparam logic [MODE_W-1:0] MODE_CLOSE     = 3'd1;
   localparam logic [MODE_W-1:0] MODE_GET_INIT  = 3'd2;
   localparam logic [MODE_W-1:0] MODE_GET       = 3'd3;
   localparam logic [MODE_W-1:0] MODE_RESET_ALL = 3'd4;

   localparam logic [STATUS_W-1:0] STAT_OK          = 3'd0;
   localparam logic [STATUS_W-1:0] STAT_INVALID     = 3'd1;
   localparam logic [STATUS_W-1:0] STAT_STALE       = 3'd2;
   localparam logic [STATUS_W-1:0] STAT_EXHAUSTED   = 3'd3;
   localparam logic [STATUS_W-1:0] STAT_NOT_INIT    = 3'd4;
   localparam logic [STATUS_W-1:0] STAT_INIT_FAILED = 3'd5;

   typedef struct packed {
      logic [MODE_W-1:0] mode;
      logic [SLOT_W-1:0] slot;
      logic [GEN_W-1:0]  handle_gen;
      logic              init_ok;
      logic [VAL_W-1:0]  init_value;
   } req_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [SLOT_W-1:0]   new_slot;
      logic [GEN_W-1:0]    new_gen;
      logic [VAL_W-1:0]    value_out;
      logic                cell_ready;
   } rsp_type;

   typedef struct packed {
      logic              wr_en;
      logic [SLOT_W-1:0] wr_addr;
      logic [GEN_W-1:0]  wr_data;
      logic              rd_a_en;
      logic [SLOT_W-1:0] rd_a_addr;
      logic              rd_b_en;
      logic [SLOT_W-1:0] rd_b_addr;
   } gen_mem_req_type;

   typedef struct packed {
      logic              wr_en;
      logic [SLOT_W-1:0] wr_addr;
      logic [VAL_W-1:0]  wr_data;
      logic              rd_en;
      logic [SLOT_W-1:0] rd_addr;
   } val_mem_req_type;

   typedef struct packed {
      logic start;
      logic step;
   } scan_ctl_type;

   typedef struct packed {
      logic              hit;
      logic              last;
      logic [SLOT_W-1:0] idx;
   } scan_res_type;

   // next generation, skipping zero on wrap
   function automatic logic [GEN_W-1:0] gen_advance(input logic [GEN_W-1:0] g);
      gen_advance = (g == '1) ? GEN_W'(1) : g + GEN_W'(1);
   endfunction

endpackage

[rtl/gct_chan_if.sv]
// valid/ready channel carrying one payload per transaction
interface gct_chan_if #(parameter type payload_type = logic) ();
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

[rtl/gct_gen_mem.sv]
// generation memory: one write port, two registered read ports, written bits
module gct_gen_mem #(
   parameter int CELLS = 16
) (
   input  logic                     clock,
   input  logic                     reset,
   input  gct_pkg::gen_mem_req_type mem_req,
   output logic [gct_pkg::GEN_W-1:0] rd_a_data,
   output logic [gct_pkg::GEN_W-1:0] rd_b_data
);
   import gct_pkg::*;

   localparam int IDX_W = (CELLS > 1) ? $clog2(CELLS) : 1;

   logic [GEN_W-1:0] mem [CELLS];
   logic [CELLS-1:0] written_ff;
   logic [GEN_W-1:0] rd_a_ff;
   logic [GEN_W-1:0] rd_b_ff;
   logic             rd_a_vld_ff;
   logic             rd_b_vld_ff;

   // never-written entries read as generation zero
   always_ff @(posedge clock) begin
      if (reset) begin
         written_ff <= '0;
      end else if (mem_req.wr_en) begin
         written_ff[mem_req.wr_addr[IDX_W-1:0]] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_req.wr_en) begin
         mem[mem_req.wr_addr[IDX_W-1:0]] <= mem_req.wr_data;
      end
      if (mem_req.rd_a_en) begin
         rd_a_ff     <= mem[mem_req.rd_a_addr[IDX_W-1:0]];
         rd_a_vld_ff <= written_ff[mem_req.rd_a_addr[IDX_W-1:0]];
      end
      if (mem_req.rd_b_en) begin
         rd_b_ff     <= mem[mem_req.rd_b_addr[IDX_W-1:0]];
         rd_b_vld_ff <= written_ff[mem_req.rd_b_addr[IDX_W-1:0]];
      end
   end

   assign rd_a_data = rd_a_vld_ff ? rd_a_ff : '0;
   assign rd_b_data = rd_b_vld_ff ? rd_b_ff : '0;

endmodule

[rtl/gct_val_mem.sv]
// cell value memory: one write port, one registered read port
module gct_val_mem #(
   parameter int CELLS = 16
) (
   input  logic                     clock,
   input  gct_pkg::val_mem_req_type mem_req,
   output logic [gct_pkg::VAL_W-1:0] rd_data
);
   import gct_pkg::*;

   localparam int IDX_W = (CELLS > 1) ? $clog2(CELLS) : 1;

   logic [VAL_W-1:0] mem [CELLS];
   logic [VAL_W-1:0] rd_ff;

   // only read back once the init flag is set, so no reset is needed
   always_ff @(posedge clock) begin
      if (mem_req.wr_en) begin
         mem[mem_req.wr_addr[IDX_W-1:0]] <= mem_req.wr_data;
      end
      if (mem_req.rd_en) begin
         rd_ff <= mem[mem_req.rd_addr[IDX_W-1:0]];
      end
   end

   assign rd_data = rd_ff;

endmodule

[rtl/gct_free_scan.sv]
// lowest free cell search, one group of cells per cycle
module gct_free_scan #(
   parameter int CELLS = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic [CELLS-1:0]      alive,
   input  gct_pkg::scan_ctl_type scan_ctl,
   output gct_pkg::scan_res_type scan_res
);
   import gct_pkg::*;

   localparam int GROUPS = (CELLS + GROUP_W - 1) / GROUP_W;
   localparam int GRP_W  = (GROUPS > 1) ? $clog2(GROUPS) : 1;
   localparam int PAD_W  = GROUPS * GROUP_W;

   logic [GRP_W-1:0]       grp_ff;
   logic [GRP_W-1:0]       grp_in;
   logic [PAD_W-1:0]       busy;
   logic [GROUP_W-1:0]     slice;
   logic [GROUP_IDX_W-1:0] pos;
   logic                   hit;

   always_comb begin
      // cells past the end look occupied
      busy = '1;
      busy[CELLS-1:0] = alive;
      slice = GROUP_W'(busy >> {grp_ff, {GROUP_IDX_W{1'b0}}});
      hit = 1'b0;
      pos = '0;
      for (int k = GROUP_W - 1; k >= 0; k--) begin
         if (!slice[k]) begin
            hit = 1'b1;
            pos = GROUP_IDX_W'(k);
         end
      end
   end

   always_comb begin
      grp_in = grp_ff;
      if (scan_ctl.start) begin
         grp_in = '0;
      end else if (scan_ctl.step) begin
         grp_in = grp_ff + GRP_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         grp_ff <= '0;
      end else begin
         grp_ff <= grp_in;
      end
   end

   assign scan_res.hit  = hit;
   assign scan_res.last = (grp_ff == GRP_W'(GROUPS - 1));
   assign scan_res.idx  = SLOT_W'({grp_ff, pos});

endmodule

[rtl/generational_once_cell_table.sv]
// top level of the generational once-cell table
//
// req_bus takes one transaction per operation (mode, slot, handle_gen, init_ok,
// init_value); rsp_bus returns exactly one result per operation, in order.
// Both channels move a transaction when valid and ready are high at a clock edge.
// Operations run one at a time. For close, get, get-or-init and unknown modes
// the generation and value memories are read at accept, and the result is
// computed and written back in the execute state, which waits while an
// earlier result is still unaccepted. Create first runs the free-cell search,
// 16 cells per cycle, and reset-all first walks the generation memory below the
// high-water mark, one read and one write per retired cell.
// A finished result waits in the output register; the next transaction is
// accepted meanwhile, and only its final cycle waits for rsp_bus.ready.
// Reset (synchronous, active high) clears alive, init and written flags and the
// high-water mark at once; there is no clearing pass.
`include "generational_once_cell_table_assert.svh"

module generational_once_cell_table #(
   parameter int CELLS = 16
) (
   input logic        clock,
   input logic        reset,
   gct_chan_if.sink   req_bus,
   gct_chan_if.source rsp_bus
);
   import gct_pkg::*;

   localparam int IDX_W = (CELLS > 1) ? $clog2(CELLS) : 1;
   localparam int CNT_W = $clog2(CELLS + 1);
   localparam logic [SLOT_W:0] SLOT_LIM = (SLOT_W + 1)'(CELLS);

   typedef enum logic [4:0] {
      S_IDLE    = 5'b00001,
      S_SCAN    = 5'b00010,
      S_WALK_RD = 5'b00100,
      S_WALK_WR = 5'b01000,
      S_EXEC    = 5'b10000
   } state_type;

   state_type         state_ff, state_in;
   req_type           item_ff, item_in;
   logic [CELLS-1:0]  alive_ff, alive_in;
   logic [CELLS-1:0]  init_ff, init_in;
   logic [CNT_W-1:0]  hw_ff, hw_in;
   logic [CNT_W-1:0]  walk_ff, walk_in;
   logic              found_ff, found_in;
   logic [SLOT_W-1:0] new_idx_ff, new_idx_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_ff, rsp_in;

   gen_mem_req_type   gen_req;
   val_mem_req_type   val_req;
   scan_ctl_type      scan_ctl;
   scan_res_type      scan_res;
   logic [GEN_W-1:0]  gen_a_data;
   logic [GEN_W-1:0]  gen_b_data;
   logic [VAL_W-1:0]  val_data;

   logic              req_slot_ok;
   logic              slot_ok;
   logic [IDX_W-1:0]  si;
   logic [IDX_W-1:0]  ni;
   logic              cur;
   logic              init_pre;
   logic [STATUS_W-1:0] chk;
   logic [GEN_W-1:0]  gen_bumped;
   logic              exec_fire;

   gct_gen_mem #(.CELLS(CELLS)) u_gen_mem (
      .clock     (clock),
      .reset     (reset),
      .mem_req   (gen_req),
      .rd_a_data (gen_a_data),
      .rd_b_data (gen_b_data)
   );

   gct_val_mem #(.CELLS(CELLS)) u_val_mem (
      .clock   (clock),
      .mem_req (val_req),
      .rd_data (val_data)
   );

   gct_free_scan #(.CELLS(CELLS)) u_free_scan (
      .clock    (clock),
      .reset    (reset),
      .alive    (alive_ff),
      .scan_ctl (scan_ctl),
      .scan_res (scan_res)
   );

   assign req_bus.ready   = (state_ff == S_IDLE);
   assign rsp_bus.valid   = rsp_valid_ff;
   assign rsp_bus.payload = rsp_ff;

   assign req_slot_ok = ({1'b0, req_bus.payload.slot} < SLOT_LIM);
   assign slot_ok     = ({1'b0, item_ff.slot} < SLOT_LIM);
   assign si          = item_ff.slot[IDX_W-1:0];
   assign ni          = new_idx_ff[IDX_W-1:0];
   assign exec_fire   = (state_ff == S_EXEC) && (!rsp_valid_ff || rsp_bus.ready);

   // handle check against the state before the operation
   always_comb begin
      cur      = slot_ok && alive_ff[si] && (gen_b_data == item_ff.handle_gen);
      init_pre = slot_ok && init_ff[si];
      if (!slot_ok) begin
         chk = STAT_INVALID;
      end else if (!cur) begin
         chk = STAT_STALE;
      end else begin
         chk = STAT_OK;
      end
      gen_bumped = gen_advance(gen_a_data);
   end

   always_comb begin
      state_in     = state_ff;
      item_in      = item_ff;
      alive_in     = alive_ff;
      init_in      = init_ff;
      hw_in        = hw_ff;
      walk_in      = walk_ff;
      found_in     = found_ff;
      new_idx_in   = new_idx_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_bus.ready;
      rsp_in       = rsp_ff;
      gen_req      = '0;
      val_req      = '0;
      scan_ctl     = '0;

      case (state_ff)
         S_IDLE: begin
            if (req_bus.valid) begin
               item_in           = req_bus.payload;
               gen_req.rd_b_en   = req_slot_ok;
               gen_req.rd_b_addr = req_bus.payload.slot;
               val_req.rd_en     = req_slot_ok;
               val_req.rd_addr   = req_bus.payload.slot;
               scan_ctl.start    = 1'b1;
               walk_in           = '0;
               case (req_bus.payload.mode)
                  MODE_CREATE:    state_in = S_SCAN;
                  MODE_RESET_ALL: state_in = S_WALK_RD;
                  default:        state_in = S_EXEC;
               endcase
            end
         end
         S_SCAN: begin
            if (scan_res.hit) begin
               found_in          = 1'b1;
               new_idx_in        = scan_res.idx;
               gen_req.rd_a_en   = 1'b1;
               gen_req.rd_a_addr = scan_res.idx;
               state_in          = S_EXEC;
            end else if (scan_res.last) begin
               found_in = 1'b0;
               state_in = S_EXEC;
            end else begin
               scan_ctl.step = 1'b1;
            end
         end
         S_WALK_RD: begin
            if (walk_ff < hw_ff) begin
               gen_req.rd_a_en   = 1'b1;
               gen_req.rd_a_addr = SLOT_W'(walk_ff);
               state_in          = S_WALK_WR;
            end else begin
               state_in = S_EXEC;
            end
         end
         S_WALK_WR: begin
            gen_req.wr_en   = 1'b1;
            gen_req.wr_addr = SLOT_W'(walk_ff);
            gen_req.wr_data = gen_bumped;
            walk_in         = walk_ff + CNT_W'(1);
            state_in        = S_WALK_RD;
         end
         S_EXEC: begin
            if (exec_fire) begin
               rsp_in        = '0;
               rsp_in.status = chk;
               case (item_ff.mode)
                  MODE_CREATE: begin
                     if (found_ff) begin
                        gen_req.wr_en     = 1'b1;
                        gen_req.wr_addr   = new_idx_ff;
                        gen_req.wr_data   = gen_bumped;
                        alive_in[ni]      = 1'b1;
                        init_in[ni]       = 1'b0;
                        if (CNT_W'(new_idx_ff) >= hw_ff) begin
                           hw_in = CNT_W'(new_idx_ff) + CNT_W'(1);
                        end
                        rsp_in.status     = STAT_OK;
                        rsp_in.new_slot   = new_idx_ff;
                        rsp_in.new_gen    = gen_bumped;
                        // the new cell itself starts uninitialized
                        rsp_in.cell_ready = cur && init_pre && (item_ff.slot != new_idx_ff);
                     end else begin
                        rsp_in.status     = STAT_EXHAUSTED;
                        rsp_in.cell_ready = cur && init_pre;
                     end
                  end
                  MODE_CLOSE: begin
                     if (cur) begin
                        alive_in[si] = 1'b0;
                     end
                  end
                  MODE_GET_INIT: begin
                     if (cur) begin
                        if (init_pre) begin
                           rsp_in.value_out  = val_data;
                           rsp_in.cell_ready = 1'b1;
                        end else if (item_ff.init_ok) begin
                           val_req.wr_en     = 1'b1;
                           val_req.wr_addr   = item_ff.slot;
                           val_req.wr_data   = item_ff.init_value;
                           init_in[si]       = 1'b1;
                           rsp_in.value_out  = item_ff.init_value;
                           rsp_in.cell_ready = 1'b1;
                        end else begin
                           rsp_in.status = STAT_INIT_FAILED;
                        end
                     end
                  end
                  MODE_GET: begin
                     if (cur) begin
                        if (init_pre) begin
                           rsp_in.value_out  = val_data;
                           rsp_in.cell_ready = 1'b1;
                        end else begin
                           rsp_in.status = STAT_NOT_INIT;
                        end
                     end
                  end
                  MODE_RESET_ALL: begin
                     // generations were advanced by the walk
                     rsp_in.status = STAT_OK;
                     alive_in      = '0;
                     init_in       = '0;
                     hw_in         = '0;
                  end
                  default: begin
                     rsp_in.status     = STAT_INVALID;
                     rsp_in.cell_ready = cur && init_pre;
                  end
               endcase
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         alive_ff     <= '0;
         init_ff      <= '0;
         hw_ff        <= '0;
         walk_ff      <= '0;
         found_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         alive_ff     <= alive_in;
         init_ff      <= init_in;
         hw_ff        <= hw_in;
         walk_ff      <= walk_in;
         found_ff     <= found_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff    <= item_in;
      new_idx_ff <= new_idx_in;
      rsp_ff     <= rsp_in;
   end

   `GCT_ASSERT_ALWAYS(a_alive_below_mark, (alive_ff >> hw_ff) == '0,
                      "live cell above high-water mark")
   `GCT_ASSERT_NEXT(a_create_sets_alive,
                    exec_fire && (item_ff.mode == MODE_CREATE) && found_ff,
                    alive_ff[ni], "created cell not alive")
   `GCT_ASSERT_IMPLIES(a_rsp_from_exec, $rose(rsp_valid_ff), $past(state_ff == S_EXEC),
                       "result raised outside execute")
   `GCT_ASSERT_IMPLIES(a_mark_in_range, 1'b1, hw_ff <= CNT_W'(CELLS),
                       "high-water mark beyond cell count")

endmodule
